@@ rtl/core/dpc_pkg.sv @@
package dpc_pkg;

    // Defaults of the top level parameters.
    localparam int DEF_SUBSAMPLE_STEP = 4;
    localparam int DEF_MAX_DIM        = 4096;

    // Field and register widths.
    localparam int DEPTH_W = 16;
    localparam int Z_W     = 15;
    localparam int COORD_W = 32;
    localparam int INV_W   = 24;
    localparam int CTR_W   = 16;
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int FRAC_W  = 4;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    // Datapath widths: offset magnitude, offset times depth, times reciprocal.
    localparam int MAG_W   = CTR_W;
    localparam int P1_W    = MAG_W + Z_W;
    localparam int PROD_W  = P1_W + INV_W;
    localparam int SHIFT_W = 24;

    // Register reset values.
    localparam logic [INV_W-1:0] RST_INV_FOCAL_X  = INV_W'(31957);
    localparam logic [INV_W-1:0] RST_INV_FOCAL_Y  = INV_W'(31957);
    localparam logic [CTR_W-1:0] RST_CENTER_X     = CTR_W'(5112);
    localparam logic [CTR_W-1:0] RST_CENTER_Y     = CTR_W'(3832);
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = DIM_W'(480);

    typedef enum logic [IDX_W-1:0] {
        CFG_INV_FOCAL_X  = 3'd0,
        CFG_INV_FOCAL_Y  = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic mul1;
        logic mul2;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic keep;
        logic out_full;
    } t_dp_sts;

endpackage

@@ rtl/core/dpc_pix_if.sv @@
interface dpc_pix_if import dpc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DEPTH_W-1:0] depth_mm;
    logic                      frame_start;

    modport source (output valid, output depth_mm, output frame_start, input ready);
    modport sink   (input valid, input depth_mm, input frame_start, output ready);
endinterface

@@ rtl/core/dpc_pt_if.sv @@
interface dpc_pt_if import dpc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [Z_W-1:0]            point_z;
    logic                      clipped;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output clipped, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input clipped, output ready);
endinterface

@@ rtl/core/dpc_ctrl.sv @@
module dpc_ctrl import dpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.keep) begin
                        n_state = ST_MUL1;
                    end
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // Hold the finished point until the output register can take it.
                if (!i_sts.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_mul1_after_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL1) |-> $past(o_cmd.load && i_sts.keep))
        else $error("multiply started without a kept request");

    a_done_after_mul2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ($past(r_state == ST_MUL2) || $past(r_state == ST_DONE)))
        else $error("result stage entered out of order");

    a_emit_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == ST_IDLE) && o_cmd.in_ready)
        else $error("controller not ready after delivering a point");

endmodule

@@ rtl/core/dpc_datapath.sv @@
module dpc_datapath import dpc_pkg::*; #(
    parameter int SUBSAMPLE_STEP = DEF_SUBSAMPLE_STEP,
    parameter int MAX_DIM        = DEF_MAX_DIM
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    dpc_pix_if.sink          i_pix,
    dpc_pt_if.source         o_pt
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int PH_W  = (SUBSAMPLE_STEP > 1) ? $clog2(SUBSAMPLE_STEP) : 1;
    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
    localparam logic [PH_W-1:0]  PH_LAST   = PH_W'(SUBSAMPLE_STEP - 1);

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               clip;
    } t_rs;

    // Round to nearest with ties away from zero, then saturate to 32 bits.
    function automatic t_rs round_sat(input logic [PROD_W-1:0] prod, input logic neg);
        logic [PROD_W:0]    sum;
        logic [COORD_W-1:0] mag;
        t_rs                res;
        sum = {1'b0, prod} + (PROD_W+1)'(1 << (SHIFT_W - 1));
        mag = sum[PROD_W:SHIFT_W];
        res.clip = 1'b0;
        if (neg) begin
            if (mag > 32'h8000_0000) begin
                res.val  = 32'h8000_0000;
                res.clip = 1'b1;
            end else begin
                res.val = -mag;
            end
        end else begin
            if (mag > 32'h7FFF_FFFF) begin
                res.val  = 32'h7FFF_FFFF;
                res.clip = 1'b1;
            end else begin
                res.val = mag;
            end
        end
        return res;
    endfunction

    // Configuration registers.
    logic [INV_W-1:0] r_inv_fx, r_inv_fy;
    logic [CTR_W-1:0] r_ctr_x, r_ctr_y;
    logic [DIM_W-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx <= RST_INV_FOCAL_X;
            r_inv_fy <= RST_INV_FOCAL_Y;
            r_ctr_x  <= RST_CENTER_X;
            r_ctr_y  <= RST_CENTER_Y;
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INV_FOCAL_X:  r_inv_fx <= i_cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y:  r_inv_fy <= i_cfg_data[INV_W-1:0];
                CFG_CENTER_X:     r_ctr_x  <= i_cfg_data[CTR_W-1:0];
                CFG_CENTER_Y:     r_ctr_y  <= i_cfg_data[CTR_W-1:0];
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Position counters, with phase counters that track position modulo the step.
    logic [CNT_W-1:0] r_col, r_row;
    logic [PH_W-1:0]  r_col_ph, r_row_ph;
    logic [CNT_W-1:0] col, row;
    logic [PH_W-1:0]  col_ph, row_ph;
    logic [DIM_W-1:0] col_p1, row_p1, eff_w, eff_h;
    logic             col_wrap, row_wrap, depth_pos, accept;

    assign accept    = i_cmd.load;
    assign col       = i_pix.frame_start ? '0 : r_col;
    assign row       = i_pix.frame_start ? '0 : r_row;
    assign col_ph    = i_pix.frame_start ? '0 : r_col_ph;
    assign row_ph    = i_pix.frame_start ? '0 : r_row_ph;
    assign col_p1    = DIM_W'(col) + DIM_W'(1);
    assign row_p1    = DIM_W'(row) + DIM_W'(1);
    assign eff_w     = (r_width == '0 || r_width > MAX_DIM_V) ? MAX_DIM_V : r_width;
    assign eff_h     = (r_height == '0 || r_height > MAX_DIM_V) ? MAX_DIM_V : r_height;
    assign col_wrap  = col_p1 >= eff_w;
    assign row_wrap  = row_p1 >= eff_h;
    assign depth_pos = !i_pix.depth_mm[DEPTH_W-1] && (i_pix.depth_mm != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col    <= '0;
                r_col_ph <= '0;
                if (row_wrap) begin
                    r_row    <= '0;
                    r_row_ph <= '0;
                end else begin
                    r_row    <= row_p1[CNT_W-1:0];
                    r_row_ph <= (row_ph == PH_LAST) ? '0 : row_ph + PH_W'(1);
                end
            end else begin
                r_col    <= col_p1[CNT_W-1:0];
                r_col_ph <= (col_ph == PH_LAST) ? '0 : col_ph + PH_W'(1);
                r_row    <= row;
                r_row_ph <= row_ph;
            end
        end
    end

    // Stage 0: signed Q.4 offsets from the principal point, kept as sign and magnitude.
    logic [CTR_W:0]   off_x, off_y;
    logic [MAG_W-1:0] r_mag_x, r_mag_y;
    logic             r_neg_x, r_neg_y;
    logic [Z_W-1:0]   r_depth;

    assign off_x = {1'b0, POS_W'(col), {FRAC_W{1'b0}}} - {1'b0, r_ctr_x};
    assign off_y = {1'b0, POS_W'(row), {FRAC_W{1'b0}}} - {1'b0, r_ctr_y};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg_x <= off_x[CTR_W];
            r_neg_y <= off_y[CTR_W];
            r_mag_x <= off_x[CTR_W] ? MAG_W'(-off_x) : off_x[MAG_W-1:0];
            r_mag_y <= off_y[CTR_W] ? MAG_W'(-off_y) : off_y[MAG_W-1:0];
            r_depth <= i_pix.depth_mm[Z_W-1:0];
        end
    end

    // Stage 1: offset times depth. Stage 2: times the reciprocal focal length.
    logic [P1_W-1:0]   r_p1_x, r_p1_y;
    logic [PROD_W-1:0] r_p2_x, r_p2_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p1_x <= r_mag_x * r_depth;
            r_p1_y <= r_mag_y * r_depth;
        end
        if (i_cmd.mul2) begin
            r_p2_x <= r_p1_x * r_inv_fx;
            r_p2_y <= r_p1_y * r_inv_fy;
        end
    end

    // Stage 3: rounding and saturation into the output register.
    t_rs                res_x, res_y;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_pt_x, r_pt_y;
    logic [Z_W-1:0]     r_pt_z;
    logic               r_clip;

    assign res_x = round_sat(r_p2_x, r_neg_x);
    assign res_y = round_sat(r_p2_y, r_neg_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pt_x <= res_x.val;
            r_pt_y <= res_y.val;
            r_pt_z <= r_depth;
            r_clip <= res_x.clip | res_y.clip;
        end
    end

    assign i_pix.ready   = i_cmd.in_ready;
    assign o_pt.valid    = r_out_valid;
    assign o_pt.point_x  = r_pt_x;
    assign o_pt.point_y  = r_pt_y;
    assign o_pt.point_z  = r_pt_z;
    assign o_pt.clipped  = r_clip;

    assign o_sts.in_valid = i_pix.valid;
    assign o_sts.keep     = (col_ph == '0) && (row_ph == '0) && depth_pos;
    assign o_sts.out_full = r_out_valid && !o_pt.ready;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < CNT_W'(MAX_DIM - 1)) || (r_col == CNT_W'(MAX_DIM - 1)))
        else $error("column counter beyond the largest image");

    a_z_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_pt_z != '0))
        else $error("point delivered with zero depth");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pt.ready) |=> r_out_valid && $stable(r_pt_x) &&
            $stable(r_pt_y) && $stable(r_pt_z) && $stable(r_clip))
        else $error("waiting point changed before it was taken");

endmodule

@@ rtl/core/depth_to_point_cloud_projection.sv @@
// A kept pixel's point is valid at the output once its request has passed the multiply states
// and the result state. A kept pixel holds the input through offset, two multiplier stages and
// rounding; a dropped pixel is taken without leaving idle. A waiting output stalls rounding.
// Reset (synchronous, active low) clears the position counters, loads the register defaults,
// returns the controller to idle and empties the output register.
module depth_to_point_cloud_projection import dpc_pkg::*; #(
    parameter int SUBSAMPLE_STEP = DEF_SUBSAMPLE_STEP,
    parameter int MAX_DIM        = DEF_MAX_DIM
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    dpc_pix_if.sink          i_pix,
    dpc_pt_if.source         o_pt
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dpc_datapath #(
        .SUBSAMPLE_STEP (SUBSAMPLE_STEP),
        .MAX_DIM        (MAX_DIM)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_pix      (i_pix),
        .o_pt       (o_pt)
    );

endmodule
